// File: rtl/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared types and constants of the 2D waypoint path follower.
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam int DEF_PATH_DEPTH = 16;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 46;
  localparam int ITER_W     = 6;

  localparam logic [15:0] ONE_Q14 = 16'd16384;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SETPOS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REACHED  = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_ZERO_LEG = 2'd3;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DECODE,
    CMD_MULSD,
    CMD_MULX,
    CMD_ADDX,
    CMD_MULY,
    CMD_ADDY,
    CMD_PASS,
    CMD_LOADT,
    CMD_AIM,
    CMD_SQX,
    CMD_SQY,
    CMD_SQSUM,
    CMD_SQRT,
    CMD_DIVXI,
    CMD_DIVX,
    CMD_DIVYI,
    CMD_DIVY,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       go_move;
    logic       q_full;
    logic       q_empty;
    logic       q_one;
    logic       passed;
    logic       aim_zero;
    logic       iter_last;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: rtl/wpf_ctrl.sv
// ----------------------------------------------------------------------------
// wpf_ctrl
// Sequencer: steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
module wpf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  wpf_pkg::dp_stat_t stat,
  output wpf_pkg::cmd_t    cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'b1 << 0,
    S_DEC   = 19'b1 << 1,
    S_MULSD = 19'b1 << 2,
    S_MULX  = 19'b1 << 3,
    S_ADDX  = 19'b1 << 4,
    S_MULY  = 19'b1 << 5,
    S_ADDY  = 19'b1 << 6,
    S_PASS  = 19'b1 << 7,
    S_LOADT = 19'b1 << 8,
    S_AIM   = 19'b1 << 9,
    S_SQX   = 19'b1 << 10,
    S_SQY   = 19'b1 << 11,
    S_SQSUM = 19'b1 << 12,
    S_SQRT  = 19'b1 << 13,
    S_DIVXI = 19'b1 << 14,
    S_DIVX  = 19'b1 << 15,
    S_DIVYI = 19'b1 << 16,
    S_DIVY  = 19'b1 << 17,
    S_DONE  = 19'b1 << 18
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = wpf_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = wpf_pkg::CMD_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd = wpf_pkg::CMD_DECODE;
        priority if (stat.op == wpf_pkg::OP_TICK && stat.go_move) begin
          state_nxt = S_MULSD;
        end else if (stat.op == wpf_pkg::OP_APPEND && stat.q_empty) begin
          state_nxt = S_AIM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MULSD: begin cmd = wpf_pkg::CMD_MULSD; state_nxt = S_MULX; end
      S_MULX:  begin cmd = wpf_pkg::CMD_MULX;  state_nxt = S_ADDX; end
      S_ADDX:  begin cmd = wpf_pkg::CMD_ADDX;  state_nxt = S_MULY; end
      S_MULY:  begin cmd = wpf_pkg::CMD_MULY;  state_nxt = S_ADDY; end
      S_ADDY:  begin cmd = wpf_pkg::CMD_ADDY;  state_nxt = S_PASS; end
      S_PASS: begin
        cmd = wpf_pkg::CMD_PASS;
        state_nxt = (stat.passed && !stat.q_one) ? S_LOADT : S_DONE;
      end
      S_LOADT: begin cmd = wpf_pkg::CMD_LOADT; state_nxt = S_AIM; end
      S_AIM: begin
        cmd = wpf_pkg::CMD_AIM;
        state_nxt = stat.aim_zero ? S_DONE : S_SQX;
      end
      S_SQX:   begin cmd = wpf_pkg::CMD_SQX;   state_nxt = S_SQY; end
      S_SQY:   begin cmd = wpf_pkg::CMD_SQY;   state_nxt = S_SQSUM; end
      S_SQSUM: begin cmd = wpf_pkg::CMD_SQSUM; state_nxt = S_SQRT; end
      S_SQRT: begin
        cmd = wpf_pkg::CMD_SQRT;
        if (stat.iter_last) state_nxt = S_DIVXI;
      end
      S_DIVXI: begin cmd = wpf_pkg::CMD_DIVXI; state_nxt = S_DIVX; end
      S_DIVX: begin
        cmd = wpf_pkg::CMD_DIVX;
        if (stat.iter_last) state_nxt = S_DIVYI;
      end
      S_DIVYI: begin cmd = wpf_pkg::CMD_DIVYI; state_nxt = S_DIVY; end
      S_DIVY: begin
        cmd = wpf_pkg::CMD_DIVY;
        if (stat.iter_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd       = wpf_pkg::CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/wpf_dp.sv
// ----------------------------------------------------------------------------
// wpf_dp
// Datapath: position, direction, waypoint queue, multipliers,
// serial square root and divider, result register.
// ----------------------------------------------------------------------------
module wpf_dp #(
  parameter int PATH_DEPTH = wpf_pkg::DEF_PATH_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wpf_pkg::cmd_t                   cmd,
  input  logic [wpf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [wpf_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            out_tready,
  output wpf_pkg::dp_stat_t               stat,
  output logic                            out_tvalid,
  output logic [wpf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);
  localparam int TW = CW + 1;

  // item
  logic [1:0]         op_r;
  logic signed [31:0] cx_r, cy_r;
  logic [15:0]        spd_r, dt_r;

  // path state
  logic signed [31:0] pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      cnt_r;
  logic [1:0]         status_r;

  logic [63:0]        mem [PATH_DEPTH];
  logic [63:0]        rdata_r;

  // work registers
  logic signed [31:0] tgt_x_r, tgt_y_r;
  logic [31:0]        sd_r;
  logic signed [48:0] prod_r;
  logic [30:0]        ax_r, ay_r;
  logic               negx_r, negy_r;
  logic [61:0]        acc_r, sq_r;
  logic [63:0]        src_r;
  logic [35:0]        rem_r;
  logic [31:0]        root_r;
  logic [45:0]        quo_r;
  logic [31:0]        drem_r;
  logic [wpf_pkg::ITER_W-1:0] it_r;

  logic               out_valid_r;
  logic [wpf_pkg::OUT_DATA_W-1:0] out_data_r;

  // ---- queue addressing
  logic [AW-1:0] head_inc, tail, raddr;
  logic [TW-1:0] tsum;
  logic          re;

  assign head_inc = (head_r == AW'(PATH_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tsum     = TW'(head_r) + TW'(cnt_r);
  assign tail     = (tsum >= TW'(PATH_DEPTH)) ? AW'(tsum - TW'(PATH_DEPTH)) : AW'(tsum);
  assign raddr    = (cmd == wpf_pkg::CMD_PASS) ? head_inc : head_r;
  assign re       = (cmd == wpf_pkg::CMD_PASS) || (cmd == wpf_pkg::CMD_DECODE);

  logic q_full, q_empty, do_append;
  assign q_full    = (cnt_r == CW'(PATH_DEPTH));
  assign q_empty   = (cnt_r == '0);
  assign do_append = (cmd == wpf_pkg::CMD_DECODE) && (op_r == wpf_pkg::OP_APPEND) && !q_full;

  always_ff @(posedge clk) begin
    if (do_append) mem[tail] <= {cy_r, cx_r};
    if (re)        rdata_r   <= mem[raddr];
  end

  // ---- step along the leg
  logic signed [15:0] mul_dir;
  logic signed [48:0] prod_nxt, prod_rnd;
  logic signed [26:0] step;
  logic signed [33:0] sum_n;
  logic signed [31:0] pos_sel, pos_new;

  assign mul_dir  = (cmd == wpf_pkg::CMD_MULY) ? dir_y_r : dir_x_r;
  assign prod_nxt = mul_dir * $signed({1'b0, sd_r});
  assign pos_sel  = (cmd == wpf_pkg::CMD_ADDY) ? pos_y_r : pos_x_r;
  assign prod_rnd = prod_r + 49'sd2097152;
  assign step     = prod_rnd[48:22];
  assign sum_n    = {{7{step[26]}}, step} + {{2{pos_sel[31]}}, pos_sel};

  always_comb begin
    if (sum_n > 34'sh07FFFFFFF)       pos_new = 32'sh7FFFFFFF;
    else if (sum_n < -34'sh080000000) pos_new = 32'sh80000000;
    else                              pos_new = sum_n[31:0];
  end

  logic passed;
  assign passed = (dir_x_r > 0 && pos_x_r >= tgt_x_r) ||
                  (dir_x_r < 0 && pos_x_r <= tgt_x_r) ||
                  (dir_y_r > 0 && pos_y_r >= tgt_y_r) ||
                  (dir_y_r < 0 && pos_y_r <= tgt_y_r);

  // ---- aim: difference, magnitude, pre-scale
  logic signed [32:0] dx, dy;
  logic [32:0]        mx, my, sx, sy;
  logic               aim_zero;

  assign dx = {tgt_x_r[31], tgt_x_r} - {pos_x_r[31], pos_x_r};
  assign dy = {tgt_y_r[31], tgt_y_r} - {pos_y_r[31], pos_y_r};
  assign mx = dx[32] ? 33'(-dx) : 33'(dx);
  assign my = dy[32] ? 33'(-dy) : 33'(dy);
  assign aim_zero = (dx == '0) && (dy == '0);

  always_comb begin
    priority if (mx[32] || my[32]) begin
      sx = mx >> 2;
      sy = my >> 2;
    end else if (mx[31] || my[31]) begin
      sx = mx >> 1;
      sy = my >> 1;
    end else begin
      sx = mx;
      sy = my;
    end
  end

  // ---- square root step
  logic [35:0] rem_sh, trial;
  logic        sq_ge;
  assign rem_sh = {rem_r[33:0], src_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // ---- divide step
  logic [32:0] rem2;
  logic        dv_ge;
  logic [45:0] quo_nxt;
  logic [15:0] q_clamp, q_signed;
  logic        neg_sel;

  assign rem2    = {drem_r, quo_r[45]};
  assign dv_ge   = (rem2 >= {1'b0, root_r});
  assign quo_nxt = {quo_r[44:0], dv_ge};
  assign q_clamp = (quo_nxt > 46'(wpf_pkg::ONE_Q14)) ? wpf_pkg::ONE_Q14 : quo_nxt[15:0];
  assign neg_sel = (cmd == wpf_pkg::CMD_DIVY) ? negy_r : negx_r;
  assign q_signed = neg_sel ? 16'(-q_clamp) : q_clamp;

  logic [30:0] div_a;
  assign div_a = (cmd == wpf_pkg::CMD_DIVYI) ? ay_r : ax_r;

  logic [30:0] sq_in;
  assign sq_in = (cmd == wpf_pkg::CMD_SQY) ? ay_r : ax_r;

  // ---- control-visible state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (cmd)
        wpf_pkg::CMD_DECODE: begin
          if (op_r == wpf_pkg::OP_APPEND && !q_full) begin
            cnt_r <= cnt_r + CW'(1);
          end else if (op_r == wpf_pkg::OP_SETPOS) begin
            pos_x_r <= cx_r;
            pos_y_r <= cy_r;
            head_r  <= '0;
            cnt_r   <= '0;
            dir_x_r <= '0;
            dir_y_r <= '0;
          end
        end
        wpf_pkg::CMD_ADDX: pos_x_r <= pos_new;
        wpf_pkg::CMD_ADDY: pos_y_r <= pos_new;
        wpf_pkg::CMD_PASS: begin
          if (passed) begin
            pos_x_r <= tgt_x_r;
            pos_y_r <= tgt_y_r;
            head_r  <= head_inc;
            cnt_r   <= cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              dir_x_r <= '0;
              dir_y_r <= '0;
            end
          end
        end
        wpf_pkg::CMD_AIM: begin
          if (aim_zero) begin
            dir_x_r <= '0;
            dir_y_r <= '0;
          end
        end
        wpf_pkg::CMD_DIVX: if (it_r == '0) dir_x_r <= q_signed;
        wpf_pkg::CMD_DIVY: if (it_r == '0) dir_y_r <= q_signed;
        default: ;
      endcase
    end
  end

  // ---- work registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      wpf_pkg::CMD_LOAD: begin
        op_r  <= in_tuser;
        cx_r  <= in_tdata[31:0];
        cy_r  <= in_tdata[63:32];
        spd_r <= in_tdata[79:64];
        dt_r  <= in_tdata[95:80];
      end
      wpf_pkg::CMD_DECODE: begin
        status_r <= (op_r == wpf_pkg::OP_APPEND && q_full) ? wpf_pkg::ST_REJECT
                                                          : wpf_pkg::ST_OK;
        tgt_x_r  <= cx_r;
        tgt_y_r  <= cy_r;
      end
      wpf_pkg::CMD_MULSD: begin
        sd_r    <= spd_r * dt_r;
        tgt_x_r <= rdata_r[31:0];
        tgt_y_r <= rdata_r[63:32];
      end
      wpf_pkg::CMD_MULX, wpf_pkg::CMD_MULY: prod_r <= prod_nxt;
      wpf_pkg::CMD_PASS: if (passed) status_r <= wpf_pkg::ST_REACHED;
      wpf_pkg::CMD_LOADT: begin
        tgt_x_r <= rdata_r[31:0];
        tgt_y_r <= rdata_r[63:32];
      end
      wpf_pkg::CMD_AIM: begin
        if (aim_zero) status_r <= wpf_pkg::ST_ZERO_LEG;
        ax_r   <= sx[30:0];
        ay_r   <= sy[30:0];
        negx_r <= dx[32];
        negy_r <= dy[32];
      end
      wpf_pkg::CMD_SQX: acc_r <= sq_in * sq_in;
      wpf_pkg::CMD_SQY: sq_r  <= sq_in * sq_in;
      wpf_pkg::CMD_SQSUM: begin
        src_r  <= {1'b0, 63'(acc_r) + 63'(sq_r)};
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= wpf_pkg::ITER_W'(wpf_pkg::SQRT_STEPS - 1);
      end
      wpf_pkg::CMD_SQRT: begin
        src_r <= {src_r[61:0], 2'b00};
        if (sq_ge) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
        it_r <= it_r - 1'b1;
      end
      wpf_pkg::CMD_DIVXI, wpf_pkg::CMD_DIVYI: begin
        quo_r  <= {div_a, 15'b0} - 46'({div_a, 14'b0}) + 46'(root_r >> 1);
        drem_r <= '0;
        it_r   <= wpf_pkg::ITER_W'(wpf_pkg::DIV_STEPS - 1);
      end
      wpf_pkg::CMD_DIVX, wpf_pkg::CMD_DIVY: begin
        quo_r  <= quo_nxt;
        drem_r <= dv_ge ? 32'(rem2 - {1'b0, root_r}) : rem2[31:0];
        it_r   <= it_r - 1'b1;
      end
      default: ;
    endcase
  end

  // ---- result register
  logic [4:0] left5;
  assign left5 = (CW >= 5) ? 5'(cnt_r) : 5'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == wpf_pkg::CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == wpf_pkg::CMD_OUT)
      out_data_r <= {1'b0, status_r, left5, dir_y_r, dir_x_r, pos_y_r, pos_x_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    stat.op        = op_r;
    stat.go_move   = !q_empty && (dir_x_r != '0 || dir_y_r != '0);
    stat.q_full    = q_full;
    stat.q_empty   = q_empty;
    stat.q_one     = (cnt_r == CW'(1));
    stat.passed    = passed;
    stat.aim_zero  = aim_zero;
    stat.iter_last = (it_r == '0);
    stat.out_free  = !out_valid_r || out_tready;
  end

endmodule

// File: rtl/waypoint_path_follower_2d.sv
// ----------------------------------------------------------------------------
// waypoint_path_follower_2d
// Moves one 2D fixed-point point along a queue of waypoints.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                               | tuser
//  ---------+-----+--------------------------------------------------+--------
//  in_      | in  | coord_x 32, coord_y 32, speed 16, delta_time 16  | opcode
//  out_     | out | pos_x 32, pos_y 32, dir_x 16, dir_y 16,          | -
//           |     | waypoints_left 5, status 2, pad 1                |
//
//  One item at a time. Set position, an append to a non-empty queue and a
//  still tick just load, decode and output; a moving tick also steps x and y,
//  and one that reaches a waypoint and aims at the next, as does an append to
//  an empty queue, does 32 root steps and two 46-step divides on a non-zero leg.
//  Reset (rst_n low, synchronous): position, direction and queue cleared.
//  A new item is taken while a result waits; a stall holds only its last step.
// ----------------------------------------------------------------------------
module waypoint_path_follower_2d #(
  parameter int PATH_DEPTH = wpf_pkg::DEF_PATH_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // coord_x, coord_y, speed, delta_time
  input  logic [wpf_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode
  input  logic [wpf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pos_x, pos_y, dir_x, dir_y, waypoints_left, status, zero pad
  output logic [wpf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  wpf_pkg::cmd_t     cmd;
  wpf_pkg::dp_stat_t stat;

  // sequencer
  wpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, queue memory and result register
  wpf_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/wpf_chk.sv
// ----------------------------------------------------------------------------
// wpf_chk
// Port-level checks of the waypoint path follower.
// ----------------------------------------------------------------------------
module wpf_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wpf_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[79:64]) <= 16'sd16384 &&
                    $signed(out_tdata[79:64]) >= -16'sd16384 &&
                    $signed(out_tdata[95:80]) <= 16'sd16384 &&
                    $signed(out_tdata[95:80]) >= -16'sd16384))
    else $error("direction out of range");

  a_zero_leg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[102:101] == wpf_pkg::ST_ZERO_LEG |->
      out_tdata[95:64] == '0)
    else $error("zero-length leg with non-zero direction");

endmodule

bind waypoint_path_follower_2d wpf_chk u_wpf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
